@@ rtl/core/tpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// tpsc_pkg: shared types and codes for the calibration sequencer
// Command, phase, status and reason codes, reset values of the settings,
// the result word layout and the queue write bundle.
// ----------------------------------------------------------------------------
package tpsc_pkg;

	// commands carried by a service pass
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_CAPTURE = 2'd2;
	localparam logic [1:0] CMD_CANCEL  = 2'd3;

	// calibration phase
	localparam logic [1:0] PH_DRY  = 2'd0;
	localparam logic [1:0] PH_WET  = 2'd1;
	localparam logic [1:0] PH_IDLE = 2'd2;

	// published status
	localparam logic [2:0] ST_DRY       = 3'd0;
	localparam logic [2:0] ST_WET       = 3'd1;
	localparam logic [2:0] ST_IDLE      = 3'd2;
	localparam logic [2:0] ST_FAILED    = 3'd3;
	localparam logic [2:0] ST_CANCELLED = 3'd4;
	localparam logic [2:0] ST_SUCCEEDED = 3'd5;

	// published reason
	localparam logic [3:0] RS_NONE        = 4'd0;
	localparam logic [3:0] RS_ACTIVE      = 4'd1;
	localparam logic [3:0] RS_NOT_READY   = 4'd2;
	localparam logic [3:0] RS_NOT_STARTED = 4'd3;
	localparam logic [3:0] RS_SPAN        = 4'd4;
	localparam logic [3:0] RS_STORE       = 4'd5;
	localparam logic [3:0] RS_COMMAND     = 4'd6;
	localparam logic [3:0] RS_EMERGENCY   = 4'd7;
	localparam logic [3:0] RS_TIMEOUT     = 4'd8;

	// settings register indexes
	localparam logic CFG_TIMEOUT  = 1'b0;
	localparam logic CFG_MIN_SPAN = 1'b1;

	localparam logic [31:0] TIMEOUT_RST  = 32'd300000;
	localparam logic [11:0] MIN_SPAN_RST = 12'd200;

	// one result word
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  reason;
		logic [11:0] saved_dry;
		logic [11:0] saved_wet;
		logic [11:0] pending_dry;
		logic [11:0] shown_sample;
		logic        last;
	} event_t;

	// up to two words written per pass; we1 only together with we0
	typedef struct packed {
		logic   we0;
		logic   we1;
		event_t ev0;
		event_t ev1;
	} evq_wr_t;

endpackage

@@ rtl/core/tpsc_front.sv @@
// ----------------------------------------------------------------------------
// tpsc_front: pass evaluator
// Takes one service pass per cycle while the queue has room, runs the command step and the active
// check step, updates the calibration state and hands 0..2 words to the queue.
// ----------------------------------------------------------------------------
module tpsc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              room,
	input  logic              cfg_valid,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [1:0]        command,
	input  logic              controller_idle,
	input  logic              emergency_stop,
	input  logic              update_busy,
	input  logic              button_click,
	input  logic [11:0]       sample_raw,
	input  logic [31:0]       now_ms,
	input  logic              store_ok,
	output tpsc_pkg::evq_wr_t wr
);

	typedef struct packed {
		logic [1:0]  phase;
		logic [11:0] pend;
		logic [11:0] dry_ref;
		logic [11:0] wet_ref;
	} cal_state_t;

	typedef struct packed {
		cal_state_t       s;
		tpsc_pkg::event_t ev;
	} step_t;

	function automatic tpsc_pkg::event_t mk_event(logic [2:0] st, logic [3:0] rs,
			cal_state_t s, logic [11:0] shown);
		tpsc_pkg::event_t e;
		e.status       = st;
		e.reason       = rs;
		e.saved_dry    = s.dry_ref;
		e.saved_wet    = s.wet_ref;
		e.pending_dry  = s.pend;
		e.shown_sample = shown;
		e.last         = 1'b0;
		return e;
	endfunction

	function automatic step_t do_cancel(cal_state_t s, logic [3:0] rs);
		step_t r;
		r.s = s;
		if (s.phase == tpsc_pkg::PH_IDLE) begin
			r.ev = mk_event(tpsc_pkg::ST_IDLE, rs, s, 12'd0);
		end else begin
			r.s.phase = tpsc_pkg::PH_IDLE;
			// pending dry is shown before it is cleared
			r.ev = mk_event(tpsc_pkg::ST_CANCELLED, rs, r.s, 12'd0);
			r.s.pend = '0;
		end
		return r;
	endfunction

	function automatic step_t do_capture(cal_state_t s, logic [11:0] smp, logic sok,
			logic [11:0] span);
		step_t       r;
		logic [11:0] diff;
		logic        short_span;
		r.s        = s;
		diff       = s.pend - smp;
		short_span = (s.pend <= smp) || (diff < span);
		if (s.phase == tpsc_pkg::PH_IDLE) begin
			r.ev = mk_event(tpsc_pkg::ST_FAILED, tpsc_pkg::RS_NOT_STARTED, s, 12'd0);
		end else if (s.phase == tpsc_pkg::PH_DRY) begin
			r.s.pend  = smp;
			r.s.phase = tpsc_pkg::PH_WET;
			r.ev      = mk_event(tpsc_pkg::ST_WET, tpsc_pkg::RS_NONE, r.s, smp);
		end else begin
			r.s.phase = tpsc_pkg::PH_IDLE;
			if (short_span) begin
				r.ev = mk_event(tpsc_pkg::ST_FAILED, tpsc_pkg::RS_SPAN, r.s, smp);
			end else if (!sok) begin
				r.ev = mk_event(tpsc_pkg::ST_FAILED, tpsc_pkg::RS_STORE, r.s, smp);
			end else begin
				r.s.dry_ref = s.pend;
				r.s.wet_ref = smp;
				r.ev = mk_event(tpsc_pkg::ST_SUCCEEDED, tpsc_pkg::RS_NONE, r.s, smp);
			end
			r.s.pend = '0;
		end
		return r;
	endfunction

	cal_state_t       state_q;
	logic [31:0]      start_q;
	logic [31:0]      timeout_q;
	logic [11:0]      min_span_q;

	cal_state_t       s1, s2;
	logic [31:0]      start1;
	logic [31:0]      elapsed;
	step_t            ra, rb;
	logic             a_v, b_v;
	tpsc_pkg::event_t a_ev, b_ev;
	logic             accept;

	assign full   = !room;
	assign accept = push && room;

	always_comb begin
		// command step
		s1     = state_q;
		start1 = start_q;
		a_v    = 1'b0;
		a_ev   = '0;
		ra     = '0;
		unique case (command)
			tpsc_pkg::CMD_CANCEL: begin
				ra   = do_cancel(state_q, tpsc_pkg::RS_COMMAND);
				s1   = ra.s;
				a_ev = ra.ev;
				a_v  = 1'b1;
			end
			tpsc_pkg::CMD_CAPTURE: begin
				ra   = do_capture(state_q, sample_raw, store_ok, min_span_q);
				s1   = ra.s;
				a_ev = ra.ev;
				a_v  = 1'b1;
			end
			tpsc_pkg::CMD_START: begin
				a_v = 1'b1;
				if (state_q.phase != tpsc_pkg::PH_IDLE) begin
					a_ev = mk_event(tpsc_pkg::ST_FAILED, tpsc_pkg::RS_ACTIVE, state_q, 12'd0);
				end else if (!(controller_idle && !emergency_stop && !update_busy)) begin
					a_ev = mk_event(tpsc_pkg::ST_FAILED, tpsc_pkg::RS_NOT_READY, state_q,
						12'd0);
				end else begin
					s1.pend  = '0;
					s1.phase = tpsc_pkg::PH_DRY;
					start1   = now_ms;
					a_ev     = mk_event(tpsc_pkg::ST_DRY, tpsc_pkg::RS_NONE, s1, 12'd0);
				end
			end
			tpsc_pkg::CMD_NONE: begin
			end
			default: begin
			end
		endcase

		// active check step; wrapping elapsed time
		elapsed = now_ms - start1;
		s2      = s1;
		b_v     = 1'b0;
		b_ev    = '0;
		rb      = '0;
		if (s1.phase != tpsc_pkg::PH_IDLE) begin
			if (emergency_stop) begin
				rb  = do_cancel(s1, tpsc_pkg::RS_EMERGENCY);
				b_v = 1'b1;
			end else if (elapsed >= timeout_q) begin
				rb  = do_cancel(s1, tpsc_pkg::RS_TIMEOUT);
				b_v = 1'b1;
			end else if (button_click) begin
				rb  = do_capture(s1, sample_raw, store_ok, min_span_q);
				b_v = 1'b1;
			end
			if (b_v) begin
				s2   = rb.s;
				b_ev = rb.ev;
			end
		end

		// pack words, mark the final one
		if (a_v) begin
			wr.we0      = accept;
			wr.we1      = accept && b_v;
			wr.ev0      = a_ev;
			wr.ev0.last = !b_v;
			wr.ev1      = b_ev;
			wr.ev1.last = 1'b1;
		end else begin
			wr.we0      = accept && b_v;
			wr.we1      = 1'b0;
			wr.ev0      = b_ev;
			wr.ev0.last = 1'b1;
			wr.ev1      = b_ev;
			wr.ev1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase   <= tpsc_pkg::PH_IDLE;
			state_q.pend    <= '0;
			state_q.dry_ref <= '0;
			state_q.wet_ref <= '0;
			start_q         <= '0;
		end else if (accept) begin
			state_q <= s2;
			start_q <= start1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= tpsc_pkg::TIMEOUT_RST;
			min_span_q <= tpsc_pkg::MIN_SPAN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpsc_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data;
				tpsc_pkg::CFG_MIN_SPAN: min_span_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ rtl/core/tpsc_evq.sv @@
// ----------------------------------------------------------------------------
// tpsc_evq: result word queue
// Small ring buffer, up to two writes and one read per cycle; the head word
// drives the result ports directly.
// ----------------------------------------------------------------------------
module tpsc_evq #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tpsc_pkg::evq_wr_t wr,
	output logic              room,
	output logic              empty,
	input  logic              pop,
	output tpsc_pkg::event_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	tpsc_pkg::event_t mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic [PW-1:0]    wptr1;
	logic             do_pop;
	logic [CW-1:0]    n_wr;

	assign wptr1  = inc(wptr_q);
	assign empty  = (count_q == '0);
	assign room   = (count_q <= CW'(DEPTH - 2));
	assign do_pop = pop && !empty;
	assign head   = mem_q[rptr_q];
	assign n_wr   = CW'(wr.we0) + CW'(wr.we1);

	always_ff @(posedge clk) begin
		if (wr.we0) mem_q[wptr_q] <= wr.ev0;
		if (wr.we1) mem_q[wptr1] <= wr.ev1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.we1) wptr_q <= inc(wptr1);
			else if (wr.we0) wptr_q <= wptr1;
			if (do_pop) rptr_q <= inc(rptr_q);
			count_q <= count_q + n_wr - CW'(do_pop);
		end
	end

endmodule

@@ rtl/core/two_point_sensor_calibration_sequencer.sv @@
// ----------------------------------------------------------------------------
// two_point_sensor_calibration_sequencer: dry/wet sensor calibration sequencer
// Sequences idle, awaiting-dry and awaiting-wet per service pass and
// publishes status words through a small output queue.
// ----------------------------------------------------------------------------
// A service pass is accepted on push while full is low and is evaluated in
// the cycle it is taken: command first, then (while active) emergency stop,
// timeout on the wrapping 32-bit elapsed time, or a button capture. Each
// pass yields zero, one or two result words; the last word of a pass has
// last set. Words wait in an EVQ_DEPTH-deep queue and leave one per cycle
// on pop, so the sustained rate is one pass per cycle for passes with at
// most one word; when every pass yields two, the pass rate is held lower,
// bounded by the single-word result port. full rises when fewer than two
// queue slots are free. Settings (timeout_ms index 0, min_span index 1)
// are taken every cycle (cfg_ready stays high) and must be written while
// the block is idle. After reset the saved pair and pending dry are zero,
// timeout_ms is 300000 and min_span is 200.
// ----------------------------------------------------------------------------
module two_point_sensor_calibration_sequencer #(
	parameter int EVQ_DEPTH = 4   // result words buffered, at least 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// pass input
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic        controller_idle,
	input  logic        emergency_stop,
	input  logic        update_busy,
	input  logic        button_click,
	input  logic [11:0] sample_raw,
	input  logic [31:0] now_ms,
	input  logic        store_ok,
	// settings write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// result words
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [3:0]  reason,
	output logic [11:0] saved_dry,
	output logic [11:0] saved_wet,
	output logic [11:0] pending_dry_out,
	output logic [11:0] shown_sample,
	output logic        last
);

	tpsc_pkg::evq_wr_t wr;
	tpsc_pkg::event_t  head;
	logic              room;

	// settings never stall
	assign cfg_ready = 1'b1;

	// front: evaluate pass, update state, emit words
	tpsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.room            (room),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.controller_idle (controller_idle),
		.emergency_stop  (emergency_stop),
		.update_busy     (update_busy),
		.button_click    (button_click),
		.sample_raw      (sample_raw),
		.now_ms          (now_ms),
		.store_ok        (store_ok),
		.wr              (wr)
	);

	// back: word queue feeding the result ports
	tpsc_evq #(
		.DEPTH (EVQ_DEPTH)
	) u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.head   (head)
	);

	assign status          = head.status;
	assign reason          = head.reason;
	assign saved_dry       = head.saved_dry;
	assign saved_wet       = head.saved_wet;
	assign pending_dry_out = head.pending_dry;
	assign shown_sample    = head.shown_sample;
	assign last            = head.last;

endmodule

@@ rtl/core/tpsc_checker.sv @@
// ----------------------------------------------------------------------------
// tpsc_checker: port-level checks for the calibration sequencer
// Watches the result port for word contents that the sequencing guarantees.
// ----------------------------------------------------------------------------
module tpsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [3:0]  reason,
	input logic [11:0] saved_dry,
	input logic [11:0] saved_wet,
	input logic [11:0] pending_dry_out,
	input logic [11:0] shown_sample,
	input logic        last
);

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(reason)
			&& $stable(shown_sample) && $stable(last)))
		else $error("result word changed while waiting");

	// success shows the newly saved pair
	a_success: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tpsc_pkg::ST_SUCCEEDED) |->
			(reason == tpsc_pkg::RS_NONE && saved_dry == pending_dry_out
			&& saved_wet == shown_sample))
		else $error("success word does not show the saved pair");

	// dry capture shows the captured reading as pending
	a_dry_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tpsc_pkg::ST_WET) |->
			(reason == tpsc_pkg::RS_NONE && pending_dry_out == shown_sample))
		else $error("dry capture word inconsistent");

	// a start clears pending and shows no sample
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == tpsc_pkg::ST_DRY) |->
			(reason == tpsc_pkg::RS_NONE && pending_dry_out == 12'd0
			&& shown_sample == 12'd0))
		else $error("start word inconsistent");

endmodule

bind two_point_sensor_calibration_sequencer tpsc_checker u_tpsc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.status          (status),
	.reason          (reason),
	.saved_dry       (saved_dry),
	.saved_wet       (saved_wet),
	.pending_dry_out (pending_dry_out),
	.shown_sample    (shown_sample),
	.last            (last)
);
